### rtl/bfb_pkg.sv
// Package for the blind radio frame builder: command word type, frame constants,
// CRC and channel helper functions. No dependencies.
package bfb_pkg;

  localparam int FRAME_BYTES_DEF = 32;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int BIDX_W = 5;

  localparam logic [1:0] FMT_CMD = 2'd0;
  localparam logic [1:0] FMT_GROUP = 2'd1;
  localparam logic [1:0] FMT_DUP = 2'd2;
  localparam logic [1:0] FMT_NONE = 2'd3;

  localparam logic [15:0] CRC_POLY = 16'h755B;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0] PREAMBLE_BYTE = 8'h55;
  localparam logic [7:0] SYNC_BYTE = 8'hC0;
  localparam logic [7:0] CMD_LEN_BASE = 8'h10;

  localparam logic [BIDX_W-1:0] CMD_FIXED_LEN = 5'd20;
  localparam logic [BIDX_W-1:0] GROUP_LEN = 5'd14;
  localparam logic [BIDX_W-1:0] DUP_LEN = 5'd22;
  localparam logic [BIDX_W-1:0] CMD_HEAD_LEN = 5'd14;

  typedef struct packed {
    logic [1:0] frame_format;
    logic [7:0] remote_byte_0;
    logic [7:0] remote_byte_1;
    logic [7:0] remote_byte_2;
    logic [7:0] remote_byte_3;
    logic [5:0] channel_mask;
    logic [7:0] action_code;
    logic [7:0] random_first;
    logic [7:0] random_second;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_out_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [2:0] lowest_ch(input logic [5:0] mask);
    logic [2:0] ch;
    ch = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (mask[i]) begin
        ch = 3'(i + 1);
      end
    end
    return ch;
  endfunction

  function automatic logic [2:0] chan_count(input logic [5:0] mask);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 6; i++) begin
      n = n + {2'b00, mask[i]};
    end
    return n;
  endfunction

endpackage

### rtl/bfb_cmd_queue.sv
// Command queue of the frame builder: a small synchronous memory of command words
// with a registered read port feeding a one-word prefetch stage. Uses bfb_pkg.
module bfb_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bfb_pkg::item_t push_item,
  output logic           full,
  input  logic           take,
  output bfb_pkg::q_out_t q_out
);

  bfb_pkg::item_t mem [bfb_pkg::QDEPTH];

  logic [bfb_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bfb_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bfb_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       pf_valid_r, pf_valid_nxt;
  bfb_pkg::item_t             pf_item_r;
  logic                       read_en;

  assign full = (cnt_r == bfb_pkg::QCNT_W'(bfb_pkg::QDEPTH));
  assign read_en = (cnt_r != '0) && (!pf_valid_r || take);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = read_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt = cnt_r + bfb_pkg::QCNT_W'(push) - bfb_pkg::QCNT_W'(read_en);
    if (read_en) begin
      pf_valid_nxt = 1'b1;
    end else if (take) begin
      pf_valid_nxt = 1'b0;
    end else begin
      pf_valid_nxt = pf_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
    if (read_en) begin
      pf_item_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
      pf_valid_r <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
      pf_valid_r <= pf_valid_nxt;
    end
  end

  assign q_out.valid = pf_valid_r;
  assign q_out.item = pf_item_r;

endmodule

### rtl/blind_radio_frame_builder_unit.sv
// Top level of the blind radio frame builder: command queue plus the byte-serial
// frame generator with a running CRC. Uses bfb_pkg and bfb_cmd_queue.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall  | one blind command
//   out_    | output    | out_valid/out_stall| one frame byte, last and reject flags
//
// A frame is FRAME_BYTES words, one per cycle unless the output stalls; a rejected
// command gives one word. The byte generator sets the rate; frames run back to back.
// Commands wait in a four-word queue memory with a registered read. Reset is
// synchronous and clears the queue, the generator flags and the output valid flag.
// A stall on the output holds the current word; input stalls only when the queue is full.
module blind_radio_frame_builder_unit #(
  parameter int FRAME_BYTES = bfb_pkg::FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_frame_format,
  input  logic [7:0] in_remote_byte_0,
  input  logic [7:0] in_remote_byte_1,
  input  logic [7:0] in_remote_byte_2,
  input  logic [7:0] in_remote_byte_3,
  input  logic [5:0] in_channel_mask,
  input  logic [7:0] in_action_code,
  input  logic [7:0] in_random_first,
  input  logic [7:0] in_random_second,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic       out_frame_last,
  output logic       out_rejected
);

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  bfb_pkg::item_t  in_item;
  bfb_pkg::q_out_t q_out;
  logic            q_full;
  logic            take;

  bfb_pkg::item_t   cur_r, cur_nxt;
  logic             busy_r, busy_nxt;
  logic             rej_r, rej_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pad_r, pad_nxt;
  logic [POS_W-1:0] blen_r, blen_nxt;
  logic [2:0]       kcnt_r, kcnt_nxt;
  logic [5:0]       rem_r, rem_nxt;
  logic [15:0]      crc_r, crc_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_rej_r, out_rej_nxt;

  logic             adv;
  logic             finishing;
  logic [POS_W-1:0] j;
  logic [bfb_pkg::BIDX_W-1:0] jb;
  logic [bfb_pkg::BIDX_W-1:0] ch_end;
  logic [bfb_pkg::BIDX_W-1:0] tail_idx;
  logic [7:0]       body_b;
  logic             ch_slot;

  logic [1:0]       ld_fmt;
  logic [5:0]       ld_mask;
  logic             ld_rej;
  logic [2:0]       ld_k;
  logic [POS_W-1:0] ld_blen;
  logic [POS_W:0]   ld_pad;

  assign in_item.frame_format = in_frame_format;
  assign in_item.remote_byte_0 = in_remote_byte_0;
  assign in_item.remote_byte_1 = in_remote_byte_1;
  assign in_item.remote_byte_2 = in_remote_byte_2;
  assign in_item.remote_byte_3 = in_remote_byte_3;
  assign in_item.channel_mask = in_channel_mask;
  assign in_item.action_code = in_action_code;
  assign in_item.random_first = in_random_first;
  assign in_item.random_second = in_random_second;

  assign in_stall = q_full;

  bfb_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_item (in_item),
    .full      (q_full),
    .take      (take),
    .q_out     (q_out)
  );

  assign adv = busy_r && (!out_valid_r || !out_stall);
  assign finishing = rej_r || (pos_r == LAST_POS);
  assign take = q_out.valid && (!busy_r || (adv && finishing));

  assign j = pos_r - pad_r;
  assign jb = bfb_pkg::BIDX_W'(j);
  assign ch_end = bfb_pkg::CMD_HEAD_LEN + {2'b00, kcnt_r};
  assign tail_idx = jb - ch_end;
  assign ch_slot = (cur_r.frame_format == bfb_pkg::FMT_CMD) &&
                   (jb >= bfb_pkg::CMD_HEAD_LEN) && (jb < ch_end);

  always_comb begin
    body_b = 8'h00;
    case (cur_r.frame_format)
      bfb_pkg::FMT_CMD: begin
        if (jb < bfb_pkg::CMD_HEAD_LEN) begin
          case (jb)
            5'd0: body_b = cur_r.remote_byte_0;
            5'd1: body_b = cur_r.remote_byte_1;
            5'd2: body_b = bfb_pkg::SYNC_BYTE;
            5'd3: body_b = bfb_pkg::CMD_LEN_BASE + {5'b00000, kcnt_r};
            5'd4: body_b = 8'h00;
            5'd5: body_b = 8'h05;
            5'd6: body_b = cur_r.random_first;
            5'd7: body_b = 8'hFF;
            5'd8: body_b = 8'hFF;
            5'd9: body_b = cur_r.remote_byte_2;
            5'd10: body_b = cur_r.remote_byte_3;
            5'd11: body_b = 8'h86;
            5'd12: body_b = 8'h06;
            5'd13: body_b = cur_r.random_second;
            default: body_b = 8'h00;
          endcase
        end else if (ch_slot) begin
          body_b = {5'b00000, bfb_pkg::lowest_ch(rem_r)};
        end else begin
          case (tail_idx)
            5'd0: body_b = 8'h00;
            5'd1: body_b = cur_r.remote_byte_2;
            5'd2: body_b = cur_r.remote_byte_3;
            5'd3: body_b = 8'h52;
            5'd4: body_b = cur_r.action_code;
            default: body_b = 8'h00;
          endcase
        end
      end
      bfb_pkg::FMT_GROUP: begin
        case (jb)
          5'd0: body_b = cur_r.remote_byte_0;
          5'd1: body_b = cur_r.remote_byte_1;
          5'd2: body_b = bfb_pkg::SYNC_BYTE;
          5'd3: body_b = 8'h0A;
          5'd4: body_b = 8'h40;
          5'd5: body_b = 8'h05;
          5'd6: body_b = cur_r.random_first;
          5'd7: body_b = 8'hFF;
          5'd8: body_b = 8'hFF;
          5'd9: body_b = cur_r.remote_byte_2;
          5'd10: body_b = cur_r.remote_byte_3;
          5'd11: body_b = 8'h08;
          5'd12: body_b = {5'b00000, bfb_pkg::lowest_ch(cur_r.channel_mask)};
          5'd13: body_b = cur_r.action_code;
          default: body_b = 8'h00;
        endcase
      end
      default: begin
        case (jb)
          5'd0: body_b = 8'hFF;
          5'd1: body_b = 8'hFF;
          5'd2: body_b = bfb_pkg::SYNC_BYTE;
          5'd3: body_b = 8'h12;
          5'd4: body_b = 8'h80;
          5'd5: body_b = 8'h0D;
          5'd6: body_b = cur_r.random_first;
          5'd7: body_b = 8'hFF;
          5'd8: body_b = 8'hFF;
          5'd9: body_b = 8'h06;
          5'd10: body_b = 8'h03;
          5'd11: body_b = 8'h20;
          5'd12: body_b = 8'h05;
          5'd13: body_b = 8'h12;
          5'd14: body_b = 8'h03;
          5'd15: body_b = 8'hAC;
          5'd16: body_b = 8'h56;
          5'd17: body_b = cur_r.remote_byte_1;
          5'd18: body_b = cur_r.remote_byte_0;
          5'd19: body_b = cur_r.remote_byte_2;
          5'd20: body_b = cur_r.remote_byte_3;
          5'd21: body_b = 8'hC8;
          default: body_b = 8'h00;
        endcase
      end
    endcase
  end

  always_comb begin
    ld_fmt = q_out.item.frame_format;
    ld_mask = q_out.item.channel_mask;
    ld_rej = (ld_fmt == bfb_pkg::FMT_NONE) ||
             ((ld_fmt != bfb_pkg::FMT_DUP) && (ld_mask == 6'd0));
    ld_k = bfb_pkg::chan_count(ld_mask);
    case (ld_fmt)
      bfb_pkg::FMT_CMD: ld_blen = POS_W'(bfb_pkg::CMD_FIXED_LEN + {2'b00, ld_k});
      bfb_pkg::FMT_GROUP: ld_blen = POS_W'(bfb_pkg::GROUP_LEN);
      default: ld_blen = POS_W'(bfb_pkg::DUP_LEN);
    endcase
    ld_pad = (POS_W + 1)'(FRAME_BYTES) - {1'b0, ld_blen} - (POS_W + 1)'(2);
  end

  always_comb begin
    cur_nxt = cur_r;
    busy_nxt = busy_r;
    rej_nxt = rej_r;
    pos_nxt = pos_r;
    pad_nxt = pad_r;
    blen_nxt = blen_r;
    kcnt_nxt = kcnt_r;
    rem_nxt = rem_r;
    crc_nxt = crc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    out_rej_nxt = out_rej_r;

    if (adv) begin
      out_valid_nxt = 1'b1;
      out_rej_nxt = rej_r;
      out_last_nxt = finishing;
      pos_nxt = pos_r + 1'b1;
      if (finishing) begin
        busy_nxt = 1'b0;
      end
      if (rej_r) begin
        out_byte_nxt = 8'h00;
      end else if (pos_r < pad_r) begin
        out_byte_nxt = bfb_pkg::PREAMBLE_BYTE;
      end else if (j < blen_r) begin
        out_byte_nxt = body_b;
        crc_nxt = bfb_pkg::crc_byte(crc_r, body_b);
        if (ch_slot) begin
          rem_nxt = rem_r & (rem_r - 6'd1);
        end
      end else if (j == blen_r) begin
        out_byte_nxt = crc_r[15:8];
      end else begin
        out_byte_nxt = crc_r[7:0];
      end
    end

    if (take) begin
      cur_nxt = q_out.item;
      busy_nxt = 1'b1;
      rej_nxt = ld_rej;
      pos_nxt = '0;
      pad_nxt = POS_W'(ld_pad);
      blen_nxt = ld_blen;
      kcnt_nxt = ld_k;
      rem_nxt = ld_mask;
      crc_nxt = bfb_pkg::CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    pos_r <= pos_nxt;
    pad_r <= pad_nxt;
    blen_r <= blen_nxt;
    kcnt_r <= kcnt_nxt;
    rem_r <= rem_nxt;
    crc_r <= crc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_rej_r <= out_rej_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rej_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      rej_r <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_last = out_last_r;
  assign out_rejected = out_rej_r;

endmodule

### rtl/bfb_checker.sv
// Port-level checker for the blind radio frame builder, bound to the top level.
// Uses only the top-level ports.
module bfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_frame_byte,
  input logic       out_frame_last,
  input logic       out_rejected
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_byte) &&
      $stable(out_frame_last) && $stable(out_rejected))
    else $error("Stalled output word changed.");

  a_reject_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_frame_last && (out_frame_byte == 8'h00))
    else $error("Rejected word is not a single zero word.");

  a_reject_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_last |-> !out_rejected)
    else $error("Reject flag inside a frame.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid right after reset.");

endmodule

bind blind_radio_frame_builder_unit bfb_checker u_bfb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_frame_byte (out_frame_byte),
  .out_frame_last (out_frame_last),
  .out_rejected   (out_rejected)
);

### tb/sv/blind_radio_frame_builder_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for blind_radio_frame_builder_unit: directed and random blind
// commands, each predicted as a padded radio frame or a single reject word and compared
// word by word. Depends on bfb_pkg and the builder RTL only.
module blind_radio_frame_builder_unit_tb;

  localparam int FRAME_LEN = bfb_pkg::FRAME_BYTES_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 2 * FRAME_LEN + 8;

  typedef struct packed {
    logic [7:0] fbyte;
    logic       is_last;
    logic       rejected;
  } frame_word_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_frame_format;
  logic [7:0] in_remote_byte_0;
  logic [7:0] in_remote_byte_1;
  logic [7:0] in_remote_byte_2;
  logic [7:0] in_remote_byte_3;
  logic [5:0] in_channel_mask;
  logic [7:0] in_action_code;
  logic [7:0] in_random_first;
  logic [7:0] in_random_second;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_frame_byte;
  logic       out_frame_last;
  logic       out_rejected;

  frame_word_t pending_words[$];
  bit          send_gaps;
  bit          stall_bursts;
  int          mismatch_count;
  int          words_checked;
  int          cycle_count;
  int          cmd_frames;
  int          group_frames;
  int          dup_frames;
  int          rejected_cmds;

  blind_radio_frame_builder_unit #(.FRAME_BYTES(FRAME_LEN)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_format  (in_frame_format),
    .in_remote_byte_0 (in_remote_byte_0),
    .in_remote_byte_1 (in_remote_byte_1),
    .in_remote_byte_2 (in_remote_byte_2),
    .in_remote_byte_3 (in_remote_byte_3),
    .in_channel_mask  (in_channel_mask),
    .in_action_code   (in_action_code),
    .in_random_first  (in_random_first),
    .in_random_second (in_random_second),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_frame_last   (out_frame_last),
    .out_rejected     (out_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bfb_pkg::item_t make_command(input logic [1:0] fmt,
                                                  input logic [7:0] r0,
                                                  input logic [7:0] r1, input logic [7:0] r2,
                                                  input logic [7:0] r3, input logic [5:0] mask,
                                                  input logic [7:0] act,
                                                  input logic [7:0] rnd1,
                                                  input logic [7:0] rnd2);
    bfb_pkg::item_t c;
    c.frame_format = fmt;
    c.remote_byte_0 = r0;
    c.remote_byte_1 = r1;
    c.remote_byte_2 = r2;
    c.remote_byte_3 = r3;
    c.channel_mask = mask;
    c.action_code = act;
    c.random_first = rnd1;
    c.random_second = rnd2;
    return c;
  endfunction

  function automatic bfb_pkg::item_t random_command();
    int          pick;
    logic [1:0]  fmt;
    logic [5:0]  mask;
    pick = $urandom_range(0, 19);
    if (pick < 7) begin
      fmt = bfb_pkg::FMT_CMD;
    end else if (pick < 13) begin
      fmt = bfb_pkg::FMT_GROUP;
    end else if (pick < 18) begin
      fmt = bfb_pkg::FMT_DUP;
    end else begin
      fmt = bfb_pkg::FMT_NONE;
    end
    mask = ($urandom_range(0, 7) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
    return make_command(fmt, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), mask,
                        8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic void predict_frame_words(input bfb_pkg::item_t c);
    logic [7:0]  body [0:31];
    int          len;
    int          pad;
    int          count;
    logic [7:0]  lowest;
    logic [15:0] crc;
    logic        top;
    frame_word_t w;
    if (c.frame_format == bfb_pkg::FMT_NONE ||
        (c.frame_format != bfb_pkg::FMT_DUP && c.channel_mask == 6'd0)) begin
      w.fbyte = 8'h00;
      w.is_last = 1'b1;
      w.rejected = 1'b1;
      pending_words.push_back(w);
      return;
    end
    if (c.frame_format == bfb_pkg::FMT_CMD) begin
      body[0] = c.remote_byte_0;
      body[1] = c.remote_byte_1;
      body[2] = bfb_pkg::SYNC_BYTE;
      body[4] = 8'h00;
      body[5] = 8'h05;
      body[6] = c.random_first;
      body[7] = 8'hFF;
      body[8] = 8'hFF;
      body[9] = c.remote_byte_2;
      body[10] = c.remote_byte_3;
      body[11] = 8'h86;
      body[12] = 8'h06;
      body[13] = c.random_second;
      len = 14;
      count = 0;
      for (int i = 0; i < 6; i++) begin
        if (c.channel_mask[i]) begin
          body[len] = 8'(i + 1);
          len++;
          count++;
        end
      end
      body[3] = bfb_pkg::CMD_LEN_BASE + 8'(count);
      body[len] = 8'h00;
      body[len + 1] = c.remote_byte_2;
      body[len + 2] = c.remote_byte_3;
      body[len + 3] = 8'h52;
      body[len + 4] = c.action_code;
      body[len + 5] = 8'h00;
      len += 6;
    end else if (c.frame_format == bfb_pkg::FMT_GROUP) begin
      lowest = 8'h00;
      for (int i = 0; i < 6; i++) begin
        if (c.channel_mask[i] && lowest == 8'h00) begin
          lowest = 8'(i + 1);
        end
      end
      body[0] = c.remote_byte_0;
      body[1] = c.remote_byte_1;
      body[2] = bfb_pkg::SYNC_BYTE;
      body[3] = 8'h0A;
      body[4] = 8'h40;
      body[5] = 8'h05;
      body[6] = c.random_first;
      body[7] = 8'hFF;
      body[8] = 8'hFF;
      body[9] = c.remote_byte_2;
      body[10] = c.remote_byte_3;
      body[11] = 8'h08;
      body[12] = lowest;
      body[13] = c.action_code;
      len = 14;
    end else begin
      body[0] = 8'hFF;
      body[1] = 8'hFF;
      body[2] = bfb_pkg::SYNC_BYTE;
      body[3] = 8'h12;
      body[4] = 8'h80;
      body[5] = 8'h0D;
      body[6] = c.random_first;
      body[7] = 8'hFF;
      body[8] = 8'hFF;
      body[9] = 8'h06;
      body[10] = 8'h03;
      body[11] = 8'h20;
      body[12] = 8'h05;
      body[13] = 8'h12;
      body[14] = 8'h03;
      body[15] = 8'hAC;
      body[16] = 8'h56;
      body[17] = c.remote_byte_1;
      body[18] = c.remote_byte_0;
      body[19] = c.remote_byte_2;
      body[20] = c.remote_byte_3;
      body[21] = 8'hC8;
      len = 22;
    end
    crc = bfb_pkg::CRC_INIT;
    for (int i = 0; i < len; i++) begin
      crc[15:8] = crc[15:8] ^ body[i];
      for (int b = 0; b < 8; b++) begin
        top = crc[15];
        crc = crc << 1;
        if (top) begin
          crc = crc ^ bfb_pkg::CRC_POLY;
        end
      end
    end
    body[len] = crc[15:8];
    body[len + 1] = crc[7:0];
    len += 2;
    pad = (FRAME_LEN > len) ? FRAME_LEN - len : 0;
    for (int i = 0; i < pad + len; i++) begin
      w.fbyte = (i < pad) ? bfb_pkg::PREAMBLE_BYTE : body[i - pad];
      w.is_last = (i == pad + len - 1);
      w.rejected = 1'b0;
      pending_words.push_back(w);
    end
  endfunction

  task automatic send_command(input bfb_pkg::item_t c);
    int gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_format <= c.frame_format;
    in_remote_byte_0 <= c.remote_byte_0;
    in_remote_byte_1 <= c.remote_byte_1;
    in_remote_byte_2 <= c.remote_byte_2;
    in_remote_byte_3 <= c.remote_byte_3;
    in_channel_mask <= c.channel_mask;
    in_action_code <= c.action_code;
    in_random_first <= c.random_first;
    in_random_second <= c.random_second;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame_words(c);
    if (c.frame_format == bfb_pkg::FMT_NONE ||
        (c.frame_format != bfb_pkg::FMT_DUP && c.channel_mask == 6'd0)) begin
      rejected_cmds++;
    end else if (c.frame_format == bfb_pkg::FMT_CMD) begin
      cmd_frames++;
    end else if (c.frame_format == bfb_pkg::FMT_GROUP) begin
      group_frames++;
    end else begin
      dup_frames++;
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_command_frames();
    send_command(make_command(bfb_pkg::FMT_CMD, 8'h00, 8'h00, 8'h00, 8'h00, 6'h01, 8'h00,
                              8'h00, 8'h00));
    send_command(make_command(bfb_pkg::FMT_CMD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'h3F, 8'hFF,
                              8'hFF, 8'hFF));
    send_command(make_command(bfb_pkg::FMT_CMD, 8'h12, 8'h34, 8'h56, 8'h78, 6'h20, 8'h5A,
                              8'hA5, 8'h3C));
    send_command(make_command(bfb_pkg::FMT_CMD, 8'hA5, 8'h5A, 8'h0F, 8'hF0, 6'h15, 8'h01,
                              8'h80, 8'h7F));
    send_command(make_command(bfb_pkg::FMT_CMD, 8'h81, 8'h7E, 8'hC3, 8'h3C, 6'h2A, 8'h80,
                              8'h01, 8'hFE));
    wait_for_drain();
  endtask

  task automatic test_group_frames();
    send_command(make_command(bfb_pkg::FMT_GROUP, 8'h00, 8'h00, 8'h00, 8'h00, 6'h01, 8'h00,
                              8'h00, 8'hFF));
    send_command(make_command(bfb_pkg::FMT_GROUP, 8'h11, 8'h22, 8'h33, 8'h44, 6'h20, 8'h9C,
                              8'h5E, 8'h00));
    send_command(make_command(bfb_pkg::FMT_GROUP, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 6'h3E, 8'h42,
                              8'h24, 8'h99));
    send_command(make_command(bfb_pkg::FMT_GROUP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'h3F, 8'hFF,
                              8'hFF, 8'hFF));
    send_command(make_command(bfb_pkg::FMT_GROUP, 8'h01, 8'h80, 8'h02, 8'h40, 6'h0C, 8'h00,
                              8'h00, 8'h00));
    wait_for_drain();
  endtask

  task automatic test_duplicate_frames();
    send_command(make_command(bfb_pkg::FMT_DUP, 8'h00, 8'h00, 8'h00, 8'h00, 6'h00, 8'h00,
                              8'h00, 8'h00));
    send_command(make_command(bfb_pkg::FMT_DUP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'h3F, 8'hFF,
                              8'hFF, 8'hFF));
    send_command(make_command(bfb_pkg::FMT_DUP, 8'h9A, 8'h3B, 8'h6C, 8'hD1, 6'h15, 8'h77,
                              8'hE4, 8'h18));
    wait_for_drain();
  endtask

  task automatic test_rejected_commands();
    send_command(make_command(bfb_pkg::FMT_CMD, 8'h5C, 8'hC5, 8'h31, 8'h13, 6'h00, 8'h66,
                              8'h99, 8'hAA));
    send_command(make_command(bfb_pkg::FMT_GROUP, 8'hFF, 8'h00, 8'hFF, 8'h00, 6'h00, 8'hFF,
                              8'h00, 8'hFF));
    send_command(make_command(bfb_pkg::FMT_NONE, 8'h27, 8'h72, 8'hB4, 8'h4B, 6'h3F, 8'h10,
                              8'h20, 8'h30));
    send_command(make_command(bfb_pkg::FMT_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'h00, 8'hFF,
                              8'hFF, 8'hFF));
    send_command(make_command(bfb_pkg::FMT_CMD, 8'h00, 8'h00, 8'h00, 8'h00, 6'h10, 8'h00,
                              8'h00, 8'h00));
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    send_gaps = 1'b1;
    stall_bursts = 1'b1;
    repeat (150) send_command(random_command());
    wait_for_drain();
    stall_bursts = 1'b0;
    repeat (100) send_command(random_command());
    send_gaps = 1'b0;
    stall_bursts = 1'b1;
    repeat (80) send_command(random_command());
    stall_bursts = 1'b0;
    repeat (60) send_command(random_command());
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_bursts && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    frame_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected word: byte %02h last %0b rejected %0b", out_frame_byte,
                   out_frame_last, out_rejected);
        end
      end else begin
        w = pending_words.pop_front();
        if (out_frame_byte !== w.fbyte || out_frame_last !== w.is_last ||
            out_rejected !== w.rejected) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected byte %02h last %0b rejected %0b, got %02h %0b %0b",
                     w.fbyte, w.is_last, w.rejected, out_frame_byte, out_frame_last,
                     out_rejected);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d words outstanding.", pending_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_frame_format <= bfb_pkg::FMT_CMD;
    in_remote_byte_0 <= 8'h00;
    in_remote_byte_1 <= 8'h00;
    in_remote_byte_2 <= 8'h00;
    in_remote_byte_3 <= 8'h00;
    in_channel_mask <= 6'h00;
    in_action_code <= 8'h00;
    in_random_first <= 8'h00;
    in_random_second <= 8'h00;
    send_gaps = 1'b1;
    stall_bursts = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_command_frames();
    test_group_frames();
    test_duplicate_frames();
    test_rejected_commands();
    test_random_traffic();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d frame words from %0d command, %0d group and %0d duplicate frames",
             words_checked, cmd_frames, group_frames, dup_frames);
    $display("plus %0d rejected commands, with random input and output idling.",
             rejected_cmds);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d words never arrived.", mismatch_count,
               pending_words.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
